// File: src/delimited_field_prefix_filter_macros.svh
// ------------------------------------------------------------------------
// delimited_field_prefix_filter_macros.svh
// assertion macros used by the field prefix filter rtl
// ------------------------------------------------------------------------
`ifndef DELIMITED_FIELD_PREFIX_FILTER_MACROS_SVH
`define DELIMITED_FIELD_PREFIX_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during rst
`define DFPF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define DFPF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define DFPF_ASSERT_IMP(label, ante, cons)
`define DFPF_ASSERT_NXT(label, ante, cons)

`endif

`endif

// File: src/dfpf_pkg.sv
// ------------------------------------------------------------------------
// dfpf_pkg
// types and constants of the delimited field prefix filter
// ------------------------------------------------------------------------
package dfpf_pkg;

  localparam int DFPF_MAX_VALUE_BYTES = 16;
  localparam int CFG_INDEX_W          = 3;
  localparam int VALUE_W              = 128;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FIELD_INDEX  = 3'd0,
    REG_SEPARATOR    = 3'd1,
    REG_VALUE_LENGTH = 3'd2,
    REG_VALUE_LOW    = 3'd3,
    REG_VALUE_HIGH   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PHASE_SEARCH  = 2'd0,
    PHASE_COMPARE = 2'd1,
    PHASE_DECIDED = 2'd2
  } scan_phase_t;

  localparam logic [7:0]  FIELD_INDEX_RESET  = 8'd0;
  localparam logic [7:0]  SEPARATOR_RESET    = 8'd44;  // comma
  localparam logic [4:0]  VALUE_LENGTH_RESET = 5'd1;
  localparam logic [63:0] VALUE_LOW_RESET    = 64'd49; // ascii "1"
  localparam logic [63:0] VALUE_HIGH_RESET   = 64'd0;
  localparam logic [7:0]  FIELD_COUNT_MAX    = 8'hFF;

  typedef struct packed {
    logic [7:0]         field_index;
    logic [7:0]         separator;
    logic [4:0]         value_length;
    logic [VALUE_W-1:0] value;
  } dfpf_cfg_t;

endpackage

// File: src/dfpf_scan.sv
// ------------------------------------------------------------------------
// dfpf_scan
// per-line scan state and combinational byte step with line verdict
// ------------------------------------------------------------------------
module dfpf_scan
  import dfpf_pkg::*;
#(
  parameter int MAX_VALUE_BYTES = DFPF_MAX_VALUE_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  dfpf_cfg_t  cfg,
  input  logic       step,
  input  logic [7:0] line_byte,
  input  logic       end_of_line,
  output logic       verdict
);

  localparam int PosW = $clog2(MAX_VALUE_BYTES + 1);
  localparam int IdxW = (MAX_VALUE_BYTES > 1) ? $clog2(MAX_VALUE_BYTES) : 1;

  logic [7:0]      value_bytes [MAX_VALUE_BYTES];
  logic [PosW-1:0] eff_len;

  scan_phase_t     scan_phase, scan_phase_next;
  logic [7:0]      fields_seen, fields_seen_next;
  logic [PosW-1:0] compare_position, compare_position_next;
  logic            decided_match, decided_match_next;

  logic            entering;
  logic            comparing;
  logic [PosW-1:0] cur_pos;
  logic [PosW-1:0] pos_inc;

  for (genvar k = 0; k < MAX_VALUE_BYTES; k++) begin : g_value
    assign value_bytes[k] = cfg.value[8*k +: 8];
  end

  // lengths above the value store are clamped
  always_comb begin
    if (cfg.value_length > 5'(MAX_VALUE_BYTES)) begin
      eff_len = PosW'(MAX_VALUE_BYTES);
    end else begin
      eff_len = PosW'(cfg.value_length);
    end
  end

  always_comb begin
    scan_phase_next       = scan_phase;
    fields_seen_next      = fields_seen;
    compare_position_next = compare_position;
    decided_match_next    = decided_match;

    entering  = (scan_phase == PHASE_SEARCH) && (line_byte != cfg.separator)
                && (fields_seen == cfg.field_index);
    comparing = entering || (scan_phase == PHASE_COMPARE);
    cur_pos   = entering ? '0 : compare_position;
    pos_inc   = cur_pos + 1'b1;

    unique case (scan_phase) inside
      PHASE_SEARCH: begin
        if (line_byte == cfg.separator && fields_seen != FIELD_COUNT_MAX) begin
          fields_seen_next = fields_seen + 8'd1;
        end
      end
      PHASE_COMPARE, PHASE_DECIDED: begin
      end
      default: begin
      end
    endcase

    // separators are plain bytes once the compare has started
    if (comparing) begin
      if (cur_pos >= eff_len) begin
        scan_phase_next    = PHASE_DECIDED;
        decided_match_next = 1'b1;
      end else if (value_bytes[cur_pos[IdxW-1:0]] != line_byte) begin
        scan_phase_next    = PHASE_DECIDED;
        decided_match_next = 1'b0;
      end else begin
        compare_position_next = pos_inc;
        if (pos_inc >= eff_len) begin
          scan_phase_next    = PHASE_DECIDED;
          decided_match_next = 1'b1;
        end else begin
          scan_phase_next = PHASE_COMPARE;
        end
      end
    end

    verdict = (scan_phase_next == PHASE_DECIDED) && decided_match_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_line)) begin
      scan_phase       <= PHASE_SEARCH;
      fields_seen      <= '0;
      compare_position <= '0;
      decided_match    <= 1'b0;
    end else if (step) begin
      scan_phase       <= scan_phase_next;
      fields_seen      <= fields_seen_next;
      compare_position <= compare_position_next;
      decided_match    <= decided_match_next;
    end
  end

endmodule

// File: src/delimited_field_prefix_filter.sv
// ------------------------------------------------------------------------
// delimited_field_prefix_filter
// per-line test whether a chosen delimited field starts with a set value
// ------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       in         in_valid / in_stall    line_byte, end_of_line
//  out      out        out_valid / out_stall  line_matches
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one byte per cycle while the input is not stalled; the verdict of a line is
// formed from its last byte in the input register, then held in the result register
// the input stalls only while a staged line-end byte waits behind a
// verdict that is itself stalled in the result register
// rst clears the line state and loads register defaults (comma, value "1")
// ------------------------------------------------------------------------
module delimited_field_prefix_filter
  import dfpf_pkg::*;
#(
  parameter int MAX_VALUE_BYTES = DFPF_MAX_VALUE_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             line_byte,
  input  logic                   end_of_line,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   line_matches,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data
);

  `include "delimited_field_prefix_filter_macros.svh"

  dfpf_cfg_t   cfg;
  logic [7:0]  field_index;
  logic [7:0]  separator;
  logic [4:0]  value_length;
  logic [63:0] value_low_word;
  logic [63:0] value_high_word;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_eol;

  logic        out_free;
  logic        advance;
  logic        verdict;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index     <= FIELD_INDEX_RESET;
      separator       <= SEPARATOR_RESET;
      value_length    <= VALUE_LENGTH_RESET;
      value_low_word  <= VALUE_LOW_RESET;
      value_high_word <= VALUE_HIGH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FIELD_INDEX:  field_index     <= cfg_data[7:0];
        REG_SEPARATOR:    separator       <= cfg_data[7:0];
        REG_VALUE_LENGTH: value_length    <= cfg_data[4:0];
        REG_VALUE_LOW:    value_low_word  <= cfg_data;
        REG_VALUE_HIGH:   value_high_word <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg = {field_index, separator, value_length, value_high_word, value_low_word};

  // the staged byte moves on unless it ends a line and the result slot is blocked
  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && (!s1_eol || out_free);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= line_byte;
      s1_eol  <= end_of_line;
    end
  end

  dfpf_scan #(
    .MAX_VALUE_BYTES(MAX_VALUE_BYTES)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (advance),
    .line_byte  (s1_byte),
    .end_of_line(s1_eol),
    .verdict    (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_eol) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_eol) begin
      line_matches <= verdict;
    end
  end

  `DFPF_ASSERT_IMP(a_stall_needs_item, in_stall, s1_valid && s1_eol)
  `DFPF_ASSERT_IMP(a_stall_needs_full_out, !out_valid, !in_stall)
  `DFPF_ASSERT_IMP(a_mid_line_flows, s1_valid && !s1_eol, advance)
  `DFPF_ASSERT_NXT(a_line_end_gives_result, advance && s1_eol, out_valid)

endmodule

// File: sim/tb.sv
// ------------------------------------------------------------------------
// tb
// self-checking bench for the delimited field prefix filter
// ------------------------------------------------------------------------
// drives text lines byte by byte with random gaps, stalls the verdict
// channel at random, and checks each verdict against a line-level
// predictor kept in step with every accepted byte. directed tests cover
// the reset registers, the empty value, separators inside the value, the
// length clamp, field counter saturation and output backpressure. after
// that, random register settings run with mostly well-formed lines
// ------------------------------------------------------------------------
module tb
  import dfpf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET   = 1500;
  localparam int MAX_WAIT      = 11;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 500000;

  typedef logic [7:0] byte_q_t[$];

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             line_byte;
  logic                   end_of_line;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   line_matches;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [63:0]            cfg_data;

  // predictor copy of the registers and the per-line state
  dfpf_cfg_t   filter_cfg;
  logic [7:0]  fields_count = '0;
  logic [4:0]  match_pos    = '0;
  scan_phase_t scan_phase   = PHASE_SEARCH;
  logic        verdict_bit  = 1'b0;

  logic pending_verdicts[$];

  bit tx_idle_on     = 1'b0;
  bit rx_idle_on     = 1'b0;
  int rx_hold_cycles = 0;
  int bytes_sent     = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  delimited_field_prefix_filter u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .line_byte    (line_byte),
    .end_of_line  (end_of_line),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .line_matches (line_matches),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // line verdict predictor
  // ---------------------------------------------------------------------
  function automatic logic [4:0] active_length();
    if (filter_cfg.value_length > 5'(DFPF_MAX_VALUE_BYTES)) begin
      return 5'(DFPF_MAX_VALUE_BYTES);
    end
    return filter_cfg.value_length;
  endfunction

  function automatic void match_value_byte(logic [7:0] b);
    logic [4:0] len;
    len = active_length();
    if (match_pos >= len) begin
      scan_phase  = PHASE_DECIDED;
      verdict_bit = 1'b1;
    end else if (filter_cfg.value[8*match_pos +: 8] != b) begin
      scan_phase  = PHASE_DECIDED;
      verdict_bit = 1'b0;
    end else begin
      match_pos = match_pos + 5'd1;
      if (match_pos >= len) begin
        scan_phase  = PHASE_DECIDED;
        verdict_bit = 1'b1;
      end
    end
  endfunction

  function automatic void track_line_byte(logic [7:0] b, logic eol);
    case (scan_phase)
      PHASE_SEARCH: begin
        if (b == filter_cfg.separator) begin
          if (fields_count != FIELD_COUNT_MAX) fields_count = fields_count + 8'd1;
        end else if (fields_count == filter_cfg.field_index) begin
          if (active_length() == 5'd0) begin
            scan_phase  = PHASE_DECIDED;
            verdict_bit = 1'b1;
          end else begin
            scan_phase = PHASE_COMPARE;
            match_pos  = '0;
            match_value_byte(b);
          end
        end
      end
      PHASE_COMPARE: match_value_byte(b);
      default: ;
    endcase
    if (eol) begin
      pending_verdicts.push_back(scan_phase == PHASE_DECIDED ? verdict_bit : 1'b0);
      fields_count = '0;
      match_pos    = '0;
      scan_phase   = PHASE_SEARCH;
      verdict_bit  = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------
  // verdict checker and receiver
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_verdict
    logic want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("line_matches: expected none, actual %0b", line_matches);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (line_matches !== want) begin
          $error("line_matches: expected %0b, actual %0b", want, line_matches);
          error_count++;
        end
      end
    end
  end

  initial begin : verdict_receiver
    int hold;
    forever begin
      hold = rx_hold_cycles + (rx_idle_on ? $urandom_range(0, MAX_WAIT) : 0);
      rx_hold_cycles = 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic eol);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    line_byte   <= b;
    end_of_line <= eol;
    do @(posedge clk); while (in_stall);
    track_line_byte(b, eol);
    bytes_sent++;
  endtask

  task automatic send_line(input byte_q_t line);
    foreach (line[i]) send_byte(line[i], i == line.size() - 1);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // stop offering bytes and let every verdict come back
  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FIELD_INDEX:  filter_cfg.field_index          = data[7:0];
      REG_SEPARATOR:    filter_cfg.separator            = data[7:0];
      REG_VALUE_LENGTH: filter_cfg.value_length         = data[4:0];
      REG_VALUE_LOW:    filter_cfg.value[63:0]          = data;
      REG_VALUE_HIGH:   filter_cfg.value[VALUE_W-1:64]  = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(logic [7:0] fi, logic [7:0] sep, logic [4:0] vlen,
                           logic [63:0] lo, logic [63:0] hi);
    wait_for_verdicts();
    write_reg(REG_FIELD_INDEX, 64'(fi));
    write_reg(REG_SEPARATOR, 64'(sep));
    write_reg(REG_VALUE_LENGTH, 64'(vlen));
    write_reg(REG_VALUE_LOW, lo);
    write_reg(REG_VALUE_HIGH, hi);
  endtask

  // fields around the target one, the target mostly carrying the value
  // (sometimes cut short or with one bit flipped), plus pure noise lines
  function automatic void build_random_line(ref byte_q_t line);
    int nf, k, tail, start;
    logic [4:0] len;
    logic [7:0] b;
    line.delete();
    len = active_length();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 24)) line.push_back(8'($urandom_range(0, 255)));
      return;
    end
    nf = int'(filter_cfg.field_index) + $urandom_range(0, 2);
    if ($urandom_range(0, 7) == 0) nf = $urandom_range(0, filter_cfg.field_index);
    for (int f = 0; f <= nf; f++) begin
      if (f > 0) line.push_back(filter_cfg.separator);
      if (f == filter_cfg.field_index && $urandom_range(0, 9) < 7) begin
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len) : len;
        start = line.size();
        for (int j = 0; j < k; j++) line.push_back(filter_cfg.value[8*j +: 8]);
        if (k > 0 && $urandom_range(0, 4) == 0) begin
          line[start + $urandom_range(0, k - 1)] ^= 8'(1 << $urandom_range(0, 7));
        end
        tail = $urandom_range(0, 3);
      end else begin
        tail = $urandom_range(0, 4);
      end
      repeat (tail) begin
        b = 8'($urandom_range(0, 255));
        if (b == filter_cfg.separator && $urandom_range(0, 3) != 0) b = ~b;
        line.push_back(b);
      end
    end
    if (line.size() == 0) line.push_back(8'($urandom_range(0, 255)));
  endfunction

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  task automatic test_reset_defaults();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_text("1");
    send_text("12,x");
    send_text("2");
    send_text(",1");
    send_text("1xyz");
    send_line('{8'h00});
    send_line('{8'hFF});
  endtask

  task automatic test_empty_value();
    configure(8'd2, SEPARATOR_RESET, 5'd0, '0, '0);
    send_text("a,b,c");
    send_text("a,b");
    send_text("a,b,,,");
  endtask

  // value "x,y": separators inside the value are plain bytes
  task automatic test_value_with_separator();
    configure(8'd1, SEPARATOR_RESET, 5'd3, 64'h0079_2C78, '0);
    send_text("a,x,y");
    send_text("a,x,z");
    send_text("a,x");
    send_text("a,,x,y");
  endtask

  task automatic test_length_clamp();
    byte_q_t q;
    configure(8'd0, 8'h00, 5'd31, '1, '1);
    repeat (16) q.push_back(8'hFF);
    send_line(q);
    void'(q.pop_back());
    send_line(q);
    configure(8'd0, 8'hFF, 5'd16, '0, '0);
    q.delete();
    repeat (16) q.push_back(8'h00);
    send_line(q);
    q[8] = 8'h01;
    send_line(q);
  endtask

  task automatic test_field_count_saturation();
    byte_q_t q;
    configure(8'd255, SEPARATOR_RESET, 5'd1, 64'h5A, '0);
    repeat (300) q.push_back(SEPARATOR_RESET);
    q.push_back(8'h5A);
    send_line(q);
    configure(8'd254, SEPARATOR_RESET, 5'd1, 64'h5A, '0);
    q.delete();
    repeat (256) q.push_back(SEPARATOR_RESET);
    q.push_back(8'h5A);
    send_line(q);
    q.delete();
    repeat (254) q.push_back(SEPARATOR_RESET);
    q.push_back(8'h5A);
    send_line(q);
  endtask

  // verdicts back up behind a long stall until line ends stall the input
  task automatic test_output_backpressure();
    configure(FIELD_INDEX_RESET, SEPARATOR_RESET, VALUE_LENGTH_RESET,
              VALUE_LOW_RESET, VALUE_HIGH_RESET);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold_cycles = LONG_HOLD;
    repeat (12) begin
      send_text("1,ab");
      send_text("2");
    end
    wait_for_verdicts();
  endtask

  task automatic run_random_phase();
    byte_q_t line;
    logic [7:0] fi;
    int vlen, lines;
    fi   = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 5));
    vlen = $urandom_range(0, 19);
    configure(fi,
              ($urandom_range(0, 2) == 0) ? SEPARATOR_RESET : 8'($urandom_range(0, 255)),
              5'((vlen == 19) ? 31 : vlen),
              {$urandom, $urandom}, {$urandom, $urandom});
    tx_idle_on = $urandom_range(0, 3) != 0;
    rx_idle_on = $urandom_range(0, 3) != 0;
    lines = (fi == 8'hFF) ? 3 : $urandom_range(10, 30);
    for (int n = 0; n < lines && bytes_sent < ITEM_TARGET; n++) begin
      build_random_line(line);
      send_line(line);
    end
  endtask

  initial begin : main_sequence
    filter_cfg.field_index  = FIELD_INDEX_RESET;
    filter_cfg.separator    = SEPARATOR_RESET;
    filter_cfg.value_length = VALUE_LENGTH_RESET;
    filter_cfg.value        = {VALUE_HIGH_RESET, VALUE_LOW_RESET};
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    line_byte   <= '0;
    end_of_line <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_FIELD_INDEX;
    cfg_data    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_empty_value();
    test_value_with_separator();
    test_length_clamp();
    test_field_count_saturation();
    test_output_backpressure();

    while (bytes_sent < ITEM_TARGET) run_random_phase();
    wait_for_verdicts();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
